/* rtl/ple_pkg.sv */
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int LEN_W = 5;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_LIST      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_RESP,
        ACT_INS,
        ACT_DEL,
        ACT_LIST
    } act_t;

    typedef struct packed {
        act_t    act;
        status_t status;
    } ple_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_INS,
        S_INS_LAST,
        S_SHIFT_DEL,
        S_RESP,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

endpackage

`default_nettype wire

/* rtl/positional_list_engine_unit.sv */
// Top level: bounded ordered list held in a RAM, edited by a shift sequencer.
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per operation: op, value, position.
//   Output channel (out_valid/out_ready) carries result beats: status, element, last,
//   length. Every edit answers with one beat (last = 1); a list answers with one beat
//   per stored value, front to back, last set on the final one, or a single empty beat.
//   Op code seven is dropped without a result.
// Sequencing (from input accept to result loaded into the output register):
//   edits that move no stored value (back cases, errors): S_RESP only
//   insert: one S_SHIFT_INS per moved value, then S_INS_LAST, then S_RESP; delete: one
//   S_SHIFT_DEL per moved value, then S_RESP. List: S_LIST_RD then S_LIST_OUT per stored
//   value, set by the single RAM read port with registered read data.
// One operation is in flight at a time: in_ready is high only while the
// sequencer is idle, which is once the previous result is loaded. The next
// beat may be accepted while that result still waits in the output register.
// A stalled receiver holds the output register; the sequencer waits for it
// before loading another result beat.
// Reset clears the count and all control state; the list starts empty with no
// clearing pass, since slots at or beyond the count are never read.
`default_nettype none

module positional_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    op,
    input  wire logic signed [ple_pkg::VAL_W-1:0] value,
    input  wire logic [ple_pkg::POS_W-1:0]     position,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic signed [ple_pkg::VAL_W-1:0]   element,
    output logic                               last,
    output logic [ple_pkg::LEN_W-1:0]          length
);

    import ple_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    status_t            st_reg, st_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [VAL_W-1:0]   element_reg, element_next;
    logic               last_reg, last_next;
    logic [LEN_W-1:0]   length_reg, length_next;

    ple_cmd_t           cmd;
    logic [AW-1:0]      dec_idx;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VAL_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VAL_W-1:0]   mem_rdata;

    logic               accept;
    logic               push_ok;

    ple_decode #(
        .DEPTH (DEPTH)
    ) u_decode (
        .op       (op),
        .position (position),
        .count    (count_reg),
        .cmd      (cmd),
        .idx      (dec_idx)
    );

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign push_ok   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign length    = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and datapath registers need no reset
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        st_reg      <= st_next;
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
        length_reg  <= length_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.act)
                        ACT_RESP:
                        begin
                            st_next    = cmd.status;
                            state_next = S_RESP;
                        end
                        ACT_INS:
                        begin
                            if (CW'(dec_idx) == count_reg)
                            begin
                                // append: nothing to move
                                mem_we     = 1'b1;
                                mem_waddr  = dec_idx;
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                                st_next    = ST_OK;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // start moving the tail up one slot, top first
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                ptr_next   = AW'(count_reg);
                                idx_next   = dec_idx;
                                val_next   = value;
                                state_next = S_SHIFT_INS;
                            end
                        end
                        ACT_DEL:
                        begin
                            if (CW'(dec_idx) == count_reg - CW'(1))
                            begin
                                count_next = count_reg - CW'(1);
                                st_next    = ST_OK;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // close the gap from the bottom up
                                mem_re     = 1'b1;
                                mem_raddr  = dec_idx + AW'(1);
                                ptr_next   = dec_idx;
                                state_next = S_SHIFT_DEL;
                            end
                        end
                        ACT_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if (ptr_reg - AW'(1) == idx_reg)
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(2);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_INS_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                st_next    = ST_OK;
                state_next = S_RESP;
            end
            S_SHIFT_DEL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if (CW'(ptr_reg) + CW'(1) == count_reg - CW'(1))
                begin
                    count_next = count_reg - CW'(1);
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + AW'(2);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            S_RESP:
            begin
                if (push_ok)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    element_next   = '0;
                    last_next      = 1'b1;
                    length_next    = LEN_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                // read data holds here until the beat can be loaded
                if (push_ok)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    element_next   = mem_rdata;
                    last_next      = (CW'(ptr_reg) + CW'(1) == count_reg);
                    length_next    = LEN_W'(count_reg);
                    if (CW'(ptr_reg) + CW'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // count never runs past the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count beyond capacity");

    // finishing an insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_LAST |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count by one");

    // an error or empty answer is always a single final beat with a zero element
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> last_reg && element_reg == '0)
        else $error("status beat without last or with nonzero element");

    // shift writes stay inside the occupied region plus one
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_INS || state_reg == S_SHIFT_DEL)
            |-> CW'(ptr_reg) <= count_reg)
        else $error("shift write outside the list");

    // list read never reaches past the stored values
    a_list_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST_RD |-> CW'(ptr_reg) < count_reg)
        else $error("list read beyond count");

endmodule

`default_nettype wire

/* rtl/ple_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ple_decode.sv */
// Operation decode: status checks and target slot for one incoming beat.
`default_nettype none

module ple_decode #(
    parameter int DEPTH = 16
) (
    input  wire logic [2:0]                     op,
    input  wire logic [ple_pkg::POS_W-1:0]      position,
    input  wire logic [$clog2(DEPTH+1)-1:0]     count,
    output ple_pkg::ple_cmd_t                   cmd,
    output logic      [$clog2(DEPTH)-1:0]       idx
);

    import ple_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] pos_w;
    logic            full;
    logic            empty;

    assign cnt_w = CMPW'(count);
    assign pos_w = CMPW'(position);
    assign full  = (count == CW'(DEPTH));
    assign empty = (count == '0);

    always_comb
    begin
        cmd.act    = ACT_NONE;
        cmd.status = ST_OK;
        idx        = '0;
        case (op)
            OP_INS_FRONT:
            begin
                cmd.act    = full ? ACT_RESP : ACT_INS;
                cmd.status = full ? ST_FULL : ST_OK;
            end
            OP_INS_BACK:
            begin
                cmd.act    = full ? ACT_RESP : ACT_INS;
                cmd.status = full ? ST_FULL : ST_OK;
                idx        = AW'(count);
            end
            OP_INS_POS:
            begin
                if (empty || pos_w == CMPW'(1))
                begin
                    cmd.act    = full ? ACT_RESP : ACT_INS;
                    cmd.status = full ? ST_FULL : ST_OK;
                end
                else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1))
                begin
                    cmd.act    = ACT_RESP;
                    cmd.status = ST_BADPOS;
                end
                else
                begin
                    cmd.act    = full ? ACT_RESP : ACT_INS;
                    cmd.status = full ? ST_FULL : ST_OK;
                    idx        = AW'(pos_w - CMPW'(1));
                end
            end
            OP_DEL_FRONT:
            begin
                cmd.act    = empty ? ACT_RESP : ACT_DEL;
                cmd.status = empty ? ST_EMPTY : ST_OK;
            end
            OP_DEL_BACK:
            begin
                cmd.act    = empty ? ACT_RESP : ACT_DEL;
                cmd.status = empty ? ST_EMPTY : ST_OK;
                idx        = AW'(cnt_w - CMPW'(1));
            end
            OP_DEL_POS:
            begin
                if (empty)
                begin
                    cmd.act    = ACT_RESP;
                    cmd.status = ST_EMPTY;
                end
                else if (pos_w == '0 || pos_w > cnt_w)
                begin
                    cmd.act    = ACT_RESP;
                    cmd.status = ST_BADPOS;
                end
                else
                begin
                    cmd.act = ACT_DEL;
                    idx     = AW'(pos_w - CMPW'(1));
                end
            end
            OP_LIST:
            begin
                cmd.act = ACT_LIST;
            end
            default:
            begin
                cmd.act = ACT_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire
